// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/slid_pkg.sv -----
// types and constants of the sorted list block
`timescale 1ns / 1ps

package slid_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} slid_status_t;

	typedef struct packed {
		logic                    op;
		logic signed [VAL_W-1:0] value;
	} slid_in_t;

	typedef struct packed {
		slid_status_t            status;
		logic [4:0]              count;
		logic signed [VAL_W-1:0] min_value;
		logic signed [VAL_W-1:0] max_value;
		logic                    is_empty;
	} slid_out_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                    cmp;
		logic                    ins;
		logic                    del;
		logic signed [VAL_W-1:0] value;
	} slid_ctl_t;

	// what a cell shows its neighbors and the controller
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    ins_sh;
		logic                    del_sh;
		logic                    hit;
	} slid_cell_st_t;

endpackage

// ----- rtl/slid_cell.sv -----
// one cell of the sorted chain: holds an entry and shifts to or from its neighbors
`timescale 1ns / 1ps

module slid_cell import slid_pkg::*; (
	input  logic          clk,
	input  slid_ctl_t     ctl,
	input  logic          occ,
	input  slid_cell_st_t left,
	input  slid_cell_st_t right,
	output slid_cell_st_t st
);

	logic signed [VAL_W-1:0] value_q;
	logic                    ins_sh_q;
	logic                    del_sh_q;
	logic                    hit_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			ins_sh_q <= !occ || (value_q > ctl.value);
			del_sh_q <= occ && (value_q >= ctl.value);
			hit_q    <= occ && (value_q == ctl.value);
		end
		if (ctl.ins && ins_sh_q) begin
			value_q <= left.ins_sh ? left.value : ctl.value;
		end else if (ctl.del && del_sh_q) begin
			value_q <= right.value;
		end
	end

	assign st.value  = value_q;
	assign st.ins_sh = ins_sh_q;
	assign st.del_sh = del_sh_q;
	assign st.hit    = hit_q;

endmodule

// ----- rtl/sorted_list_insert_delete.sv -----
// top level of the sorted list: controller, cell chain and result register
`timescale 1ns / 1ps
// Keeps up to DEPTH signed 32-bit entries in ascending order in a chain of cells,
// one entry per cell. An insert places the value after any equal entries; a delete
// removes the first equal entry. Each beat on the item channel yields exactly one
// beat on the result channel with status, count, smallest and largest entry and an
// empty flag. From acceptance to the next acceptance an item is registered, then every
// cell compares against it at once, then the whole chain shifts, and then the result is
// gathered into the output register, which waits while an earlier result is held and not
// taken. The output register lets the next item be taken while a result still waits.
`include "assert_macros.svh"

module sorted_list_insert_delete import slid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  slid_in_t  item,
	output logic      res_valid,
	input  logic      res_ready,
	output slid_out_t res
);

	typedef enum logic [1:0] {PH_IDLE, PH_CMP, PH_UPD, PH_RES} phase_t;

	phase_t                  phase_q;
	logic                    op_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0]        count_q;
	slid_status_t            status_q;
	logic                    res_valid_q;
	slid_out_t               res_q;

	slid_ctl_t               ctl;
	slid_cell_st_t           cell_st [DEPTH];
	logic [DEPTH-1:0]        occ;
	logic [DEPTH-1:0]        last;
	logic [DEPTH-1:0]        hit;
	logic                    found;
	logic                    full;
	logic                    load_res;
	logic signed [VAL_W-1:0] max_or;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i]  = count_q > CNT_W'(i);
		assign last[i] = count_q == CNT_W'(i + 1);
		assign hit[i]  = cell_st[i].hit;

		slid_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.occ   (occ[i]),
			.left  ((i == 0) ? slid_cell_st_t'('0) : cell_st[(i == 0) ? 0 : i - 1]),
			.right (cell_st[(i == DEPTH - 1) ? i : i + 1]),
			.st    (cell_st[i])
		);
	end

	assign found    = |hit;
	assign full     = count_q == CNT_W'(DEPTH);
	assign load_res = (phase_q == PH_RES) && (!res_valid_q || res_ready);

	always_comb begin
		ctl.cmp   = phase_q == PH_CMP;
		ctl.ins   = (phase_q == PH_UPD) && (op_q == OP_INSERT) && !full;
		ctl.del   = (phase_q == PH_UPD) && (op_q == OP_DELETE) && found;
		ctl.value = value_q;
	end

	always_comb begin
		max_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			max_or = max_or | (cell_st[i].value & {VAL_W{last[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (phase_q)
				PH_IDLE: begin
					if (item_valid) begin
						phase_q <= PH_CMP;
					end
				end
				PH_CMP: begin
					phase_q <= PH_UPD;
				end
				PH_UPD: begin
					if (ctl.ins) begin
						count_q <= count_q + CNT_W'(1);
					end else if (ctl.del) begin
						count_q <= count_q - CNT_W'(1);
					end
					phase_q <= PH_RES;
				end
				PH_RES: begin
					if (load_res) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_q    <= item.op;
			value_q <= item.value;
		end
		if (phase_q == PH_UPD) begin
			if (op_q == OP_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
			end else begin
				status_q <= found ? ST_REMOVED : ST_NOT_FOUND;
			end
		end
		if (load_res) begin
			res_q.status    <= status_q;
			res_q.count     <= 5'(count_q);
			res_q.min_value <= occ[0] ? cell_st[0].value : '0;
			res_q.max_value <= max_or;
			res_q.is_empty  <= !occ[0];
		end
	end

	assign item_ready = phase_q == PH_IDLE;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(DEPTH), "entry count above depth")
	`ASSERT_PROP(a_count_hold, clk, arst_n, (phase_q != PH_UPD) |=> $stable(count_q), "count moved outside update")
	`ASSERT_PROP(a_full_hold, clk, arst_n, (phase_q == PH_UPD && op_q == OP_INSERT && full) |=> (count_q == CNT_W'(DEPTH)), "insert into full list changed count")
	`ASSERT_PROP(a_del_dec, clk, arst_n, (phase_q == PH_UPD && op_q == OP_DELETE && found) |=> (count_q == $past(count_q) - CNT_W'(1)), "delete did not drop count")
	`ASSERT_PROP(a_res_src, clk, arst_n, $rose(res_valid_q) |-> $past(phase_q == PH_RES), "result beat without gather phase")

endmodule
